FILE: rtl/core/hhls_pkg.sv
// ---------------------------------------------------------------------------
// HTTP header length scanner package
// Shared transaction types, character codes and the header prefix table.
// ---------------------------------------------------------------------------
`default_nettype none

package hhls_pkg;

  localparam int unsigned DefaultMaxBytes = 1024;
  localparam int unsigned PrefixLen       = 16;
  localparam int unsigned IdxW            = 5;
  localparam int unsigned ValueW          = 31;
  localparam int unsigned BodyW           = 11;

  localparam logic [ValueW-1:0] VALUE_MAX = {ValueW{1'b1}};

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Last three bytes of a blank line ending: CR LF CR, newest in the low byte.
  localparam logic [23:0] BLANK_TAIL = {CH_CR, CH_LF, CH_CR};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } byte_in_t;

  typedef struct packed {
    logic              length_found;
    logic [ValueW-1:0] content_length;
    logic              header_end_found;
    logic [BodyW-1:0]  body_start;
  } result_t;

  // Handshake control from the input stage to the scanner.
  typedef struct packed {
    logic step;    // the held byte is consumed this cycle
    logic report;  // that byte closes the message and yields a result
  } step_ctl_t;

  // Characters of "Content-Length: " in order.
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:  c = 8'h43;  // C
      4'd1:  c = 8'h6F;  // o
      4'd2:  c = 8'h6E;  // n
      4'd3:  c = 8'h74;  // t
      4'd4:  c = 8'h65;  // e
      4'd5:  c = 8'h6E;  // n
      4'd6:  c = 8'h74;  // t
      4'd7:  c = 8'h2D;  // -
      4'd8:  c = 8'h4C;  // L
      4'd9:  c = 8'h65;  // e
      4'd10: c = 8'h6E;  // n
      4'd11: c = 8'h67;  // g
      4'd12: c = 8'h74;  // t
      4'd13: c = 8'h68;  // h
      4'd14: c = 8'h3A;  // :
      4'd15: c = 8'h20;  // space
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hhls_in_stage.sv
// ---------------------------------------------------------------------------
// HTTP header length scanner input stage
// Holds one received byte until the scanner consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module hhls_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire hhls_pkg::byte_in_t in_item_i,
  input  wire logic              out_free_i,
  output hhls_pkg::step_ctl_t    ctl_o,
  output hhls_pkg::byte_in_t     item_o
);
  import hhls_pkg::*;

  logic     valid_q, valid_d;
  byte_in_t item_q;
  logic     advance;
  logic     accept;

  // A non-final byte never waits; a final byte waits for room in the result register.
  assign advance    = valid_q && (!item_q.final_byte || out_free_i);
  assign in_stall_o = valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign ctl_o.step   = advance;
  assign ctl_o.report = advance && item_q.final_byte;
  assign item_o       = item_q;

endmodule

`default_nettype wire

FILE: rtl/core/hhls_scan.sv
// ---------------------------------------------------------------------------
// HTTP header length scanner core
// Per-message scan state: line ends, prefix match, digit value, body start.
// ---------------------------------------------------------------------------
`default_nettype none

module hhls_scan #(
  parameter int unsigned MAX_BYTES = hhls_pkg::DefaultMaxBytes
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire hhls_pkg::step_ctl_t ctl_i,
  input  wire hhls_pkg::byte_in_t  item_i,
  output hhls_pkg::result_t        result_o
);
  import hhls_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_BYTES + 1);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_BYTES);
  localparam logic [IdxW-1:0] IdxFull = IdxW'(PrefixLen);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(PrefixLen - 1);

  logic [PosW-1:0]   pos_q, pos_d;
  logic [23:0]       recent_q, recent_d;
  logic              first_q, first_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              alive_q, alive_d;
  logic              digits_q, digits_d;
  logic [ValueW-1:0] accum_q, accum_d;
  logic              pending_q, pending_d;
  logic              found_q, found_d;
  logic [ValueW-1:0] fval_q, fval_d;
  logic              hdone_q, hdone_d;
  logic [BodyW-1:0]  body_q, body_d;

  logic [7:0]        b;
  logic              scan_en;
  logic              line_end;
  logic              blank;
  logic              is_digit;
  logic [ValueW+3:0] times_ten;
  logic [ValueW+3:0] sum;
  logic [ValueW-1:0] accum_sat;
  logic [PosW-1:0]   pos_inc;

  assign b        = item_i.data_byte;
  assign scan_en  = pos_q < MaxPos;
  assign line_end = (b == CH_LF) && (recent_q[7:0] == CH_CR);
  assign blank    = (b == CH_LF) && (recent_q == BLANK_TAIL);
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign pos_inc  = pos_q + 1'b1;

  // Multiply by ten as two shifts and an add, then saturate.
  assign times_ten = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0};
  assign sum       = times_ten + (ValueW+4)'(b - CH_ZERO);
  assign accum_sat = (sum > (ValueW+4)'(VALUE_MAX)) ? VALUE_MAX : sum[ValueW-1:0];

  always_comb begin
    pos_d     = pos_q;
    recent_d  = recent_q;
    first_d   = first_q;
    idx_d     = idx_q;
    alive_d   = alive_q;
    digits_d  = digits_q;
    accum_d   = accum_q;
    pending_d = pending_q;
    found_d   = found_q;
    fval_d    = fval_q;
    hdone_d   = hdone_q;
    body_d    = body_q;
    if (scan_en) begin
      if (!hdone_q) begin
        if (!first_q || line_end) begin
          if (line_end) begin
            first_d = 1'b1;
            if (first_q && !found_q && pending_q) begin
              found_d = 1'b1;
              fval_d  = accum_q;
            end
            idx_d     = '0;
            alive_d   = 1'b1;
            digits_d  = 1'b0;
            accum_d   = '0;
            pending_d = 1'b0;
          end
        end else if (!found_q) begin
          if (alive_q && (idx_q < IdxFull)) begin
            if (b == prefix_char(idx_q[3:0])) begin
              idx_d = idx_q + 1'b1;
              if (idx_q == IdxLast) begin
                pending_d = 1'b1;
                digits_d  = 1'b1;
                accum_d   = '0;
              end
            end else begin
              alive_d = 1'b0;
            end
          end else if (digits_q) begin
            if (is_digit) begin
              accum_d = accum_sat;
            end else begin
              digits_d = 1'b0;
            end
          end
        end
        if (blank) begin
          hdone_d = 1'b1;
          body_d  = BodyW'(pos_inc);
        end
      end
      recent_d = {recent_q[15:0], b};
      pos_d    = pos_inc;
    end
  end

  always_comb begin
    result_o.length_found     = found_d;
    result_o.content_length   = found_d ? fval_d : '0;
    result_o.header_end_found = hdone_d;
    result_o.body_start       = hdone_d ? body_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      recent_q  <= '0;
      first_q   <= 1'b0;
      idx_q     <= '0;
      alive_q   <= 1'b0;
      digits_q  <= 1'b0;
      accum_q   <= '0;
      pending_q <= 1'b0;
      found_q   <= 1'b0;
      fval_q    <= '0;
      hdone_q   <= 1'b0;
      body_q    <= '0;
    end else if (ctl_i.step) begin
      if (ctl_i.report) begin
        // The report closes the message; start clean for the next one.
        pos_q     <= '0;
        recent_q  <= '0;
        first_q   <= 1'b0;
        idx_q     <= '0;
        alive_q   <= 1'b0;
        digits_q  <= 1'b0;
        accum_q   <= '0;
        pending_q <= 1'b0;
        found_q   <= 1'b0;
        fval_q    <= '0;
        hdone_q   <= 1'b0;
        body_q    <= '0;
      end else begin
        pos_q     <= pos_d;
        recent_q  <= recent_d;
        first_q   <= first_d;
        idx_q     <= idx_d;
        alive_q   <= alive_d;
        digits_q  <= digits_d;
        accum_q   <= accum_d;
        pending_q <= pending_d;
        found_q   <= found_d;
        fval_q    <= fval_d;
        hdone_q   <= hdone_d;
        body_q    <= body_d;
      end
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxFull) else $error("prefix index past prefix length");

  a_pending_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> (idx_q == IdxFull)) else $error("value pending without full prefix");

  a_digits_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digits_q |-> pending_q) else $error("digit run outside a matched line");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= MaxPos) else $error("byte position past limit");

  a_hdr_after_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdone_q |-> first_q) else $error("blank line seen before first line end");

endmodule

`default_nettype wire

FILE: rtl/core/hhls_out_stage.sv
// ---------------------------------------------------------------------------
// HTTP header length scanner result stage
// Result register that holds a report until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module hhls_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire hhls_pkg::result_t result_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output hhls_pkg::result_t      out_item_o
);
  import hhls_pkg::*;

  logic    valid_q, valid_d;
  result_t item_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |-> !load_i) else $error("report overwritten while stalled");

endmodule

`default_nettype wire

FILE: rtl/core/http_header_length_scanner.sv
// ---------------------------------------------------------------------------
// HTTP header length scanner
// Scans a message byte stream for the header end and the Content-Length value.
// ---------------------------------------------------------------------------
// The block takes one message byte per transaction and accepts a new byte in
// every cycle unless a final byte is stalled; a byte waits in the input
// register and then moves through the scanner, so the sustained rate is one
// byte per clock without a stall. A report passes through the result register
// to the output. The loop through the scan state (line tracking, prefix match
// and the multiply-by-ten digit accumulator) sets that rate. Lines after the
// first are compared case-sensitively with "Content-Length: "; the first
// such line that ends in CR LF gives the reported value, saturated at
// 2^31-1. The first CR LF CR LF ends the header, and the offset of the byte
// after it is reported as the body start; bytes past MAX_BYTES are not
// scanned. Only a byte marked final produces a result transaction, and the
// scan state then clears for the next message. A final byte waits in the
// input register only while the previous report is still held by a stall.
// ---------------------------------------------------------------------------
`default_nettype none

module http_header_length_scanner #(
  parameter int unsigned MAX_BYTES = hhls_pkg::DefaultMaxBytes
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire hhls_pkg::byte_in_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output hhls_pkg::result_t       out_item_o
);
  import hhls_pkg::*;

  step_ctl_t ctl;
  byte_in_t  held_item;
  result_t   report;
  logic      out_free;

  // Input register: holds the byte the scanner works on this cycle.
  hhls_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_free_i (out_free),
    .ctl_o      (ctl),
    .item_o     (held_item)
  );

  // Scan state and the per-byte update logic.
  hhls_scan #(
    .MAX_BYTES (MAX_BYTES)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .item_i   (held_item),
    .result_o (report)
  );

  // Result register, loaded on a final byte.
  hhls_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ctl.report),
    .result_i    (report),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
